[rtl/ctif_pkg.sv]
package ctif_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FLAG_W     = 5;
    localparam int TDATA_W    = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SECOND_LIMIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MINUTE_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOUR_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_COMP_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_LIMIT     = 3'd4;

    localparam logic [7:0]  SECOND_LIMIT_RST    = 8'd9;
    localparam logic [7:0]  MINUTE_LIMIT_RST    = 8'd59;
    localparam logic [15:0] HOUR_LIMIT_RST      = 16'd3599;
    localparam logic [15:0] TEMP_COMP_LIMIT_RST = 16'd299;
    localparam logic [15:0] POWER_LIMIT_RST     = 16'd59;

    // flag bit positions, same order as ack_mask
    localparam int FLAG_SEC  = 0;
    localparam int FLAG_MIN  = 1;
    localparam int FLAG_HOUR = 2;
    localparam int FLAG_TEMP = 3;
    localparam int FLAG_PWR  = 4;

    typedef struct packed {
        logic [7:0]  second_limit;
        logic [7:0]  minute_limit;
        logic [15:0] hour_limit;
        logic [15:0] temp_comp_limit;
        logic [15:0] power_limit;
    } limits_t;

endpackage

[rtl/ctif_cfg.sv]
module ctif_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [ctif_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ctif_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ctif_pkg::limits_t                limits
);

    ctif_pkg::limits_t limits_reg;
    ctif_pkg::limits_t limits_next;

    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                ctif_pkg::REG_SECOND_LIMIT:    limits_next.second_limit    = cfg_data[7:0];
                ctif_pkg::REG_MINUTE_LIMIT:    limits_next.minute_limit    = cfg_data[7:0];
                ctif_pkg::REG_HOUR_LIMIT:      limits_next.hour_limit      = cfg_data;
                ctif_pkg::REG_TEMP_COMP_LIMIT: limits_next.temp_comp_limit = cfg_data;
                ctif_pkg::REG_POWER_LIMIT:     limits_next.power_limit     = cfg_data;
                default:                       limits_next = limits_reg;  // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.second_limit    <= ctif_pkg::SECOND_LIMIT_RST;
            limits_reg.minute_limit    <= ctif_pkg::MINUTE_LIMIT_RST;
            limits_reg.hour_limit      <= ctif_pkg::HOUR_LIMIT_RST;
            limits_reg.temp_comp_limit <= ctif_pkg::TEMP_COMP_LIMIT_RST;
            limits_reg.power_limit     <= ctif_pkg::POWER_LIMIT_RST;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

    assign limits = limits_reg;

endmodule

[rtl/ctif_core.sv]
module ctif_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [ctif_pkg::FLAG_W-1:0]   ack_mask,
    input  ctif_pkg::limits_t             limits,
    output logic [ctif_pkg::FLAG_W-1:0]   flags_next
);

    logic [7:0]                  tick_count_reg,      tick_count_next;
    logic [7:0]                  minute_count_reg,    minute_count_next;
    logic [15:0]                 hour_count_reg,      hour_count_next;
    logic [15:0]                 temp_comp_count_reg, temp_comp_count_next;
    logic [15:0]                 power_count_reg,     power_count_next;
    logic [ctif_pkg::FLAG_W-1:0] flag_bits_reg;

    logic [7:0]  tick_inc, minute_inc;
    logic [15:0] hour_inc, temp_inc, power_inc;
    logic        sec_wrap, min_wrap, hour_wrap, temp_wrap, power_wrap;

    always_comb
    begin
        tick_inc   = tick_count_reg + 8'd1;
        minute_inc = minute_count_reg + 8'd1;
        hour_inc   = hour_count_reg + 16'd1;
        temp_inc   = temp_comp_count_reg + 16'd1;
        power_inc  = power_count_reg + 16'd1;

        sec_wrap   = tick_inc > limits.second_limit;
        // slower counters advance only on a second wrap
        min_wrap   = sec_wrap && (minute_inc > limits.minute_limit);
        hour_wrap  = sec_wrap && (hour_inc > limits.hour_limit);
        temp_wrap  = sec_wrap && (temp_inc > limits.temp_comp_limit);
        power_wrap = sec_wrap && (power_inc > limits.power_limit);

        tick_count_next = sec_wrap ? 8'd0 : tick_inc;
        minute_count_next    = !sec_wrap ? minute_count_reg    : (min_wrap   ? 8'd0  : minute_inc);
        hour_count_next      = !sec_wrap ? hour_count_reg      : (hour_wrap  ? 16'd0 : hour_inc);
        temp_comp_count_next = !sec_wrap ? temp_comp_count_reg : (temp_wrap  ? 16'd0 : temp_inc);
        power_count_next     = !sec_wrap ? power_count_reg     : (power_wrap ? 16'd0 : power_inc);

        // clear acknowledged flags first, then set from this tick
        flags_next = flag_bits_reg & ~ack_mask;
        flags_next[ctif_pkg::FLAG_SEC]  = flags_next[ctif_pkg::FLAG_SEC]  | sec_wrap;
        flags_next[ctif_pkg::FLAG_MIN]  = flags_next[ctif_pkg::FLAG_MIN]  | min_wrap;
        flags_next[ctif_pkg::FLAG_HOUR] = flags_next[ctif_pkg::FLAG_HOUR] | hour_wrap;
        flags_next[ctif_pkg::FLAG_TEMP] = flags_next[ctif_pkg::FLAG_TEMP] | temp_wrap;
        flags_next[ctif_pkg::FLAG_PWR]  = flags_next[ctif_pkg::FLAG_PWR]  | power_wrap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg      <= '0;
            minute_count_reg    <= '0;
            hour_count_reg      <= '0;
            temp_comp_count_reg <= '0;
            power_count_reg     <= '0;
            flag_bits_reg       <= '0;
        end
        else if (accept)
        begin
            tick_count_reg      <= tick_count_next;
            minute_count_reg    <= minute_count_next;
            hour_count_reg      <= hour_count_next;
            temp_comp_count_reg <= temp_comp_count_next;
            power_count_reg     <= power_count_next;
            flag_bits_reg       <= flags_next;
        end
    end

endmodule

[rtl/cascaded_tick_interval_flags_top.sv]
// Each accepted tick beat's flags go into the result register, which drives m_tvalid/m_tdata.
// Throughput: one tick per cycle while s_tready high; counter and flag logic is combinational.
// The single result register refills in the cycle it is drained, so s_tready stays high
// unless a result is held with m_tready low.
// Reset: rst_n (async, active low) clears all counters and flags, empties the result
// register and loads the default limits.
module cascaded_tick_interval_flags_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ctif_pkg::TDATA_W-1:0]        s_tdata,   // [4:0] ack_mask, [7:5] zero
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ctif_pkg::TDATA_W-1:0]        m_tdata,   // [0] second_flag, [1] minute_flag,
                                                           // [2] hour_flag, [3] temp_comp_flag,
                                                           // [4] power_flag, [7:5] zero
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ctif_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ctif_pkg::CFG_DATA_W-1:0]     cfg_data
);

    ctif_pkg::limits_t            limits;
    logic                         accept;
    logic [ctif_pkg::FLAG_W-1:0]  flags_next;
    logic                         out_valid_reg;
    logic [ctif_pkg::FLAG_W-1:0]  out_flags_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    ctif_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    ctif_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .ack_mask   (s_tdata[ctif_pkg::FLAG_W-1:0]),
        .limits     (limits),
        .flags_next (flags_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the result until the beat is taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_flags_reg <= flags_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ctif_pkg::TDATA_W - ctif_pkg::FLAG_W){1'b0}}, out_flags_reg};

endmodule

[rtl/ctif_checker.sv]
module ctif_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ctif_pkg::TDATA_W-1:0]    m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid && (m_tdata[7:5] == 3'b000))
        else $error("accepted tick gave no clean result beat");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

bind cascaded_tick_interval_flags_top ctif_checker u_ctif_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
